// File: design/abtt_pkg.sv
// Shared types and constants for the array binary tree traversal unit.
// No dependencies; imported by array_binary_tree_traversal_unit.
`timescale 1ns / 1ps
`default_nettype none
package abtt_pkg;

  localparam int TREE_SIZE   = 32;
  localparam int ADDR_W      = $clog2(TREE_SIZE);
  localparam int IDX_W       = 6;
  localparam int CHILD_W     = IDX_W + 1;
  localparam int VAL_W       = 32;
  // Deepest path from slot 0 that stays within the TREE_SIZE slots has six nodes.
  localparam int STACK_DEPTH = 8;
  localparam int SP_IDX_W    = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  localparam logic [VAL_W-1:0] EMPTY_VAL = '1;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_PREORDER = 3'd1,
    OP_INORDER  = 3'd2,
    OP_POSTORDR = 3'd3,
    OP_DISPLAY  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    KIND_DONE       = 3'd0,
    KIND_BAD_INDEX  = 3'd1,
    KIND_NODE       = 3'd2,
    KIND_EMPTY_SLOT = 3'd3,
    KIND_EMPTY_WALK = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALL,
    S_CHECK,
    S_RET,
    S_DISP,
    S_FIN
  } state_t;

  // One suspended node of a walk: its slot, its value and whether the
  // left subtree is already done.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic             right;
  } frame_t;

endpackage
`default_nettype wire

// File: design/array_binary_tree_traversal_unit.sv
// Top level of the array binary tree traversal unit: slot store, walk stack
// and sequencer. Depends on abtt_pkg.
`timescale 1ns / 1ps
`default_nettype none
// The unit holds TREE_SIZE signed 32-bit slots (children of slot i at 2i+1
// and 2i+2), all empty (-1) after reset. An input item with tuser = 0 writes
// a slot; 1, 2 and 3 walk the subtree at slot_index in preorder, inorder or
// postorder; 4 lists every slot; codes 5 to 7 are taken and dropped. Each run
// of results ends with tlast. The unit works on one item at a time and drops
// s_tready until the run's last result is queued. One sequencer with a single
// read port on the slot store and a small stack of suspended nodes does all
// the work, stepping through a display one slot at a time and through a walk
// one visited node or empty child probe at a time; all of it stretches while
// the output side stalls. Every result passes through a one-deep holding
// register so that tlast can be set on the final one once the walk is known
// to be over.
module array_binary_tree_traversal_unit
  import abtt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [39:0] s_tdata,   // [5:0] slot_index, [37:6] node_value, [39:38] zero
  input  wire logic [2:0]  s_tuser,   // [2:0] op
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata,   // [31:0] out_value, [37:32] out_index, [39:38] zero
  output      logic [2:0]  m_tuser,   // [2:0] kind
  output      logic        m_tlast
);

  localparam logic [CHILD_W-1:0] TS_C = CHILD_W'(TREE_SIZE);
  localparam logic [ADDR_W-1:0]  LAST_SLOT = ADDR_W'(TREE_SIZE - 1);

  // Input fields
  logic [IDX_W-1:0] in_idx;
  logic [VAL_W-1:0] in_val;
  op_t              in_op;
  assign in_idx = s_tdata[IDX_W-1:0];
  assign in_val = s_tdata[IDX_W+VAL_W-1:IDX_W];
  assign in_op  = op_t'(s_tuser);

  // Sequencer state
  state_t            state, state_next;
  op_t               order, order_next;
  logic [CHILD_W-1:0] cur_idx, cur_idx_next;
  logic [ADDR_W-1:0] disp_idx, disp_idx_next;

  // Slot store with per-slot valid bits; an unwritten slot reads as empty
  logic [VAL_W-1:0]  mem [TREE_SIZE];
  logic [TREE_SIZE-1:0] vld;
  logic [VAL_W-1:0]  rdata;
  logic              rvalid;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [VAL_W-1:0]  rval;
  logic              occ;

  // Walk stack
  frame_t            stk [STACK_DEPTH];
  logic [SP_W-1:0]   sp;
  logic [SP_IDX_W-1:0] top_ptr;
  frame_t            top;
  logic              push, pop, set_right;

  // Holding register and output register
  logic              pend_valid;
  kind_t             pend_kind;
  logic [VAL_W-1:0]  pend_val;
  logic [IDX_W-1:0]  pend_idx;
  kind_t             out_kind;
  logic [VAL_W-1:0]  out_val;
  logic [IDX_W-1:0]  out_idx;
  logic              out_last;
  logic              out_valid;
  logic              out_free;
  logic              emit_ok;

  // Emission request from the sequencer
  logic              emit, fin;
  kind_t             e_kind;
  logic [VAL_W-1:0]  e_val;
  logic [IDX_W-1:0]  e_idx;
  logic              need;

  assign rval    = rvalid ? rdata : EMPTY_VAL;
  assign occ     = (rval != EMPTY_VAL);
  assign top_ptr = SP_IDX_W'(sp - SP_W'(1));
  assign top     = stk[top_ptr];
  assign out_free = !out_valid || m_tready;
  assign emit_ok  = !pend_valid || out_free;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_idx, out_val};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    order_next    = order;
    cur_idx_next  = cur_idx;
    disp_idx_next = disp_idx;
    rd_addr       = cur_idx[ADDR_W-1:0];
    mem_we        = 1'b0;
    emit          = 1'b0;
    fin           = 1'b0;
    e_kind        = KIND_NODE;
    e_val         = '0;
    e_idx         = cur_idx[IDX_W-1:0];
    push          = 1'b0;
    pop           = 1'b0;
    set_right     = 1'b0;
    need          = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          case (in_op)
            OP_INSERT: begin
              emit  = 1'b1;
              e_idx = in_idx;
              if ({1'b0, in_idx} >= TS_C) begin
                e_kind = KIND_BAD_INDEX;
              end else begin
                e_kind = KIND_DONE;
                mem_we = 1'b1;
              end
              state_next = S_FIN;
            end
            OP_PREORDER, OP_INORDER, OP_POSTORDR: begin
              order_next   = in_op;
              cur_idx_next = {1'b0, in_idx};
              if ({1'b0, in_idx} >= TS_C) begin
                // root out of range: empty walk
                emit       = 1'b1;
                e_kind     = KIND_EMPTY_WALK;
                e_idx      = in_idx;
                state_next = S_FIN;
              end else begin
                rd_addr    = in_idx[ADDR_W-1:0];
                state_next = S_CHECK;
              end
            end
            OP_DISPLAY: begin
              disp_idx_next = '0;
              rd_addr       = '0;
              state_next    = S_DISP;
            end
            default: begin
              // unknown op: take it and drop it
            end
          endcase
        end
      end
      S_CALL: begin
        if (cur_idx >= TS_C) begin
          state_next = S_RET;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!occ) begin
          if (sp == '0) begin
            emit       = 1'b1;
            e_kind     = KIND_EMPTY_WALK;
            state_next = S_FIN;
          end else begin
            state_next = S_RET;
          end
        end else begin
          need = (order == OP_PREORDER);
          if (!need || emit_ok) begin
            emit         = need;
            e_val        = rval;
            push         = 1'b1;
            cur_idx_next = {cur_idx[IDX_W-1:0], 1'b1};
            state_next   = S_CALL;
          end
        end
      end
      S_RET: begin
        if (sp == '0) begin
          state_next = S_FIN;
        end else if (!top.right) begin
          need = (order == OP_INORDER);
          if (!need || emit_ok) begin
            emit         = need;
            e_val        = top.val;
            e_idx        = top.idx;
            set_right    = 1'b1;
            cur_idx_next = {top.idx, 1'b0} + CHILD_W'(2);
            state_next   = S_CALL;
          end
        end else begin
          need = (order == OP_POSTORDR);
          if (!need || emit_ok) begin
            emit  = need;
            e_val = top.val;
            e_idx = top.idx;
            pop   = 1'b1;
          end
        end
      end
      S_DISP: begin
        rd_addr = disp_idx;
        if (emit_ok) begin
          emit   = 1'b1;
          e_idx  = IDX_W'(disp_idx);
          e_kind = occ ? KIND_NODE : KIND_EMPTY_SLOT;
          e_val  = occ ? rval : '0;
          if (disp_idx == LAST_SLOT) begin
            state_next = S_FIN;
          end else begin
            disp_idx_next = disp_idx + ADDR_W'(1);
            rd_addr       = disp_idx + ADDR_W'(1);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    order    <= order_next;
    cur_idx  <= cur_idx_next;
    disp_idx <= disp_idx_next;
  end

  // Slot store: one write port for inserts, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_idx[ADDR_W-1:0]] <= in_val;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rvalid <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[in_idx[ADDR_W-1:0]] <= 1'b1;
      end
      rvalid <= vld[rd_addr];
    end
  end

  // Walk stack: push a checked node, flag its left side done, pop it
  always_ff @(posedge clk) begin
    if (push) begin
      stk[sp[SP_IDX_W-1:0]] <= '{idx: cur_idx[IDX_W-1:0], val: rval, right: 1'b0};
    end
    if (set_right) begin
      stk[top_ptr].right <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (push) begin
      sp <= sp + SP_W'(1);
    end else if (pop) begin
      sp <= sp - SP_W'(1);
    end
  end

  // Holding register feeds the output register; the final result of a run
  // leaves with tlast set
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end
      end else if (fin) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pend_kind <= e_kind;
      pend_val  <= e_val;
      pend_idx  <= e_idx;
    end
    if ((emit && pend_valid) || fin) begin
      out_kind <= pend_kind;
      out_val  <= pend_val;
      out_idx  <= pend_idx;
      out_last <= fin;
    end
  end

`ifndef ASSERT_OFF
  // Nothing is left in the holding register between runs
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("holding register busy while idle");

  // Every run reaches its end with a result waiting to take tlast
  a_fin_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> pend_valid)
    else $error("run ended without a pending result");

  // The stack never overflows and is empty outside a walk
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    (sp <= SP_W'(STACK_DEPTH)) && ((state != S_IDLE) || (sp == '0)))
    else $error("walk stack out of bounds");

  // A released result never overwrites one the sink has not taken
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready && (emit || fin)) |-> !pend_valid || !out_valid)
    else $error("output register overrun");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb_array_binary_tree_traversal_unit.sv
// Self-checking testbench for array_binary_tree_traversal_unit: inserts, tree
// walks and slot listings checked against a predictor of the slot store.
// Depends on abtt_pkg and the unit's RTL; needs no other file.
`timescale 1ns / 1ps
module tb_array_binary_tree_traversal_unit;
  import abtt_pkg::*;

  // Op codes that the unit takes and drops without a result.
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int IDLE_LIMIT  = 3000;  // cycles with no item moving on either side
  localparam int DRAIN_WAIT  = 200;   // wait after the last expected result
  localparam int RANDOM_OPS  = 210;

  typedef struct packed {
    kind_t            kind;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic             last;
  } tree_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [5:0] slot_index, [37:6] node_value, [39:38] zero
  logic [2:0]  s_tuser = '0;   // [2:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [31:0] out_value, [37:32] out_index, [39:38] zero
  logic [2:0]  m_tuser;        // [2:0] kind
  logic        m_tlast;

  // Predicted contents of the slot store and results still to come.
  logic [VAL_W-1:0] tree_slots [TREE_SIZE];
  tree_result_t     pending_tree_results [$];

  int  fail_count      = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  walks_sent      = 0;
  int  listings_sent   = 0;
  int  idle_cycles     = 0;
  bit  sender_calm     = 1'b0;
  bit  sink_calm       = 1'b0;
  int  sink_stall      = 0;

  array_binary_tree_traversal_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void add_result(kind_t kind, logic [VAL_W-1:0] value,
                                     logic [IDX_W-1:0] index);
    tree_result_t r;
    r.kind  = kind;
    r.value = value;
    r.index = index;
    r.last  = 1'b0;
    pending_tree_results.push_back(r);
  endfunction

  function automatic bit slot_in_use(int unsigned slot);
    return slot < TREE_SIZE && tree_slots[slot] != EMPTY_VAL;
  endfunction

  // Recursive walk; the order decides where the node itself is emitted.
  function automatic void walk_subtree(int unsigned slot, logic [2:0] order);
    if (!slot_in_use(slot))
      return;
    if (order == OP_PREORDER)
      add_result(KIND_NODE, tree_slots[slot], slot[IDX_W-1:0]);
    walk_subtree(2 * slot + 1, order);
    if (order == OP_INORDER)
      add_result(KIND_NODE, tree_slots[slot], slot[IDX_W-1:0]);
    walk_subtree(2 * slot + 2, order);
    if (order == OP_POSTORDR)
      add_result(KIND_NODE, tree_slots[slot], slot[IDX_W-1:0]);
  endfunction

  function automatic void predict_tree_op(logic [2:0] op, logic [IDX_W-1:0] idx,
                                          logic [VAL_W-1:0] val);
    int before_count;
    before_count = pending_tree_results.size();
    case (op)
      OP_INSERT: begin
        if (idx >= TREE_SIZE) begin
          add_result(KIND_BAD_INDEX, '0, idx);
        end else begin
          tree_slots[idx[ADDR_W-1:0]] = val;
          add_result(KIND_DONE, '0, idx);
        end
      end
      OP_PREORDER, OP_INORDER, OP_POSTORDR: begin
        if (!slot_in_use(idx))
          add_result(KIND_EMPTY_WALK, '0, idx);
        else
          walk_subtree(idx, op);
      end
      OP_DISPLAY: begin
        for (int i = 0; i < TREE_SIZE; i++) begin
          if (tree_slots[i] != EMPTY_VAL)
            add_result(KIND_NODE, tree_slots[i], i[IDX_W-1:0]);
          else
            add_result(KIND_EMPTY_SLOT, '0, i[IDX_W-1:0]);
        end
      end
      default: ;  // reserved ops: dropped, no result
    endcase
    // Flag the final result of this item's run.
    if (pending_tree_results.size() > before_count)
      pending_tree_results[pending_tree_results.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- driving

  // Send one item: optional gap, then hold valid until the unit takes it.
  // Valid stays high on return so back-to-back items follow without a gap.
  task automatic send_tree_op(logic [2:0] op, logic [IDX_W-1:0] idx,
                              logic [VAL_W-1:0] val);
    int gap_len;
    int pick;
    pick = $urandom_range(0, 99);
    if (sender_calm || pick < 55)
      gap_len = 0;
    else if (pick < 90)
      gap_len = $urandom_range(1, 3);
    else
      gap_len = $urandom_range(10, 40);
    if (gap_len > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap_len) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, val, idx};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    predict_tree_op(op, idx, val);
    items_sent++;
    if (op inside {OP_PREORDER, OP_INORDER, OP_POSTORDR})
      walks_sent++;
    if (op == OP_DISPLAY)
      listings_sent++;
  endtask

  // Output side: mostly ready, short stalls often, long ones now and then.
  always @(posedge clk) begin
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      m_tready   <= 1'b0;
    end else if (sink_calm || rst) begin
      m_tready <= 1'b1;
    end else begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        m_tready <= 1'b1;
      end else if (pick < 96) begin
        m_tready   <= 1'b0;
        sink_stall <= $urandom_range(0, 2);
      end else begin
        m_tready   <= 1'b0;
        sink_stall <= $urandom_range(20, 60);
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_tree_results.size() == 0) begin
        $error("result with none expected: kind %0d index %0d value %0d",
               m_tuser, m_tdata[37:32], $signed(m_tdata[31:0]));
        fail_count++;
      end else begin
        tree_result_t exp_r;
        exp_r = pending_tree_results.pop_front();
        results_checked++;
        if (m_tuser !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, m_tuser);
          fail_count++;
        end
        if (m_tdata[31:0] !== exp_r.value) begin
          $error("out_value: expected %0d, got %0d", $signed(exp_r.value),
                 $signed(m_tdata[31:0]));
          fail_count++;
        end
        if (m_tdata[37:32] !== exp_r.index) begin
          $error("out_index: expected %0d, got %0d", exp_r.index, m_tdata[37:32]);
          fail_count++;
        end
        if (m_tlast !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Walks on an empty store, including a root past the store, and a listing.
  task automatic test_empty_store();
    send_tree_op(OP_PREORDER, 6'd0, '0);
    send_tree_op(OP_INORDER, 6'd63, '0);
    send_tree_op(OP_POSTORDR, 6'd31, '0);
    send_tree_op(OP_DISPLAY, 6'd0, '0);
  endtask

  // Value and index extremes, writes past the store and the reserved ops.
  task automatic test_insert_edges();
    send_tree_op(OP_INSERT, 6'd0, 32'h7FFF_FFFF);
    send_tree_op(OP_INSERT, 6'd31, 32'h8000_0000);
    send_tree_op(OP_INSERT, 6'd32, 32'h1234_5678);
    send_tree_op(OP_INSERT, 6'd63, 32'hFFFF_FFFE);
    for (logic [3:0] op = OP_RSVD5; op <= OP_RSVD7; op++)
      send_tree_op(op[2:0], 6'd63, '1);
  endtask

  // Small tree: all three orders, a listing, then empty the root.
  task automatic test_small_tree();
    send_tree_op(OP_INSERT, 6'd1, 32'd0);
    send_tree_op(OP_INSERT, 6'd2, 32'hFFFF_FFFE);
    send_tree_op(OP_INSERT, 6'd3, 32'd3);
    send_tree_op(OP_INSERT, 6'd6, 32'd6);
    send_tree_op(OP_PREORDER, 6'd0, '0);
    send_tree_op(OP_INORDER, 6'd0, '0);
    send_tree_op(OP_POSTORDR, 6'd2, '0);
    send_tree_op(OP_DISPLAY, 6'd0, '0);
    send_tree_op(OP_INSERT, 6'd0, EMPTY_VAL);
    send_tree_op(OP_PREORDER, 6'd0, '0);
  endtask

  // Rounds of: maybe clear, grow a random tree from the root, walk it, with
  // some noise (bad writes, reserved ops, stray roots) mixed in.
  task automatic test_random_trees();
    int sent_start;
    int round;
    int walk_count;
    logic [2:0] order;
    logic [IDX_W-1:0] root;
    sent_start = items_sent;
    round = 0;
    while (items_sent - sent_start < RANDOM_OPS) begin
      sender_calm = (round % 3 == 1);
      sink_calm   = (round % 4 == 2);
      if ($urandom_range(0, 2) == 0) begin
        for (int i = 0; i < TREE_SIZE; i++)
          if (tree_slots[i] != EMPTY_VAL)
            send_tree_op(OP_INSERT, i[IDX_W-1:0], EMPTY_VAL);
      end
      // Grow top-down so that deep paths stay connected to the root.
      for (int i = 0; i < TREE_SIZE; i++) begin
        if ((i == 0 || slot_in_use((i - 1) / 2)) && !slot_in_use(i) &&
            $urandom_range(0, 99) < 60)
          send_tree_op(OP_INSERT, i[IDX_W-1:0],
                       ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFE : $urandom());
      end
      walk_count = $urandom_range(3, 8);
      for (int w = 0; w < walk_count; w++) begin
        int pick;
        pick  = $urandom_range(0, 99);
        order = 3'($urandom_range(OP_PREORDER, OP_POSTORDR));
        root  = (pick < 60) ? 6'd0 : IDX_W'($urandom_range(0, 14));
        if (pick < 75)
          send_tree_op(order, root, $urandom());
        else if (pick < 80)
          send_tree_op(OP_DISPLAY, IDX_W'($urandom_range(0, 63)), $urandom());
        else if (pick < 86)
          send_tree_op(OP_INSERT, IDX_W'($urandom_range(TREE_SIZE, 63)), $urandom());
        else if (pick < 92)
          send_tree_op(3'($urandom_range(OP_RSVD5, OP_RSVD7)),
                       IDX_W'($urandom_range(0, 63)), $urandom());
        else if (pick < 96)
          send_tree_op(order, IDX_W'($urandom_range(0, 63)), $urandom());
        else
          send_tree_op(OP_INSERT, IDX_W'($urandom_range(0, TREE_SIZE - 1)),
                       ($urandom_range(0, 1) == 0) ? EMPTY_VAL : $urandom());
      end
      round++;
    end
    sender_calm = 1'b0;
    sink_calm   = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < TREE_SIZE; i++)
      tree_slots[i] = EMPTY_VAL;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_store();
    test_insert_edges();
    test_small_tree();
    test_random_trees();
    s_tvalid <= 1'b0;

    while (pending_tree_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d items (%0d walks, %0d listings), %0d results checked",
             items_sent, walks_sent, listings_sent, results_checked);
    $display("with inserts at both value extremes, writes past the store and reserved ops");
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
